// ----- rtl/core/ehp_pkg.sv -----
// ----------------------------------------------------------------------------
// ehp_pkg
// Types and constants shared by the ethernet / ipv4 header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ehp_pkg;

	localparam int LEN_W  = 17;
	localparam int MAC_W  = 48;
	localparam int ETYP_W = 16;
	localparam int IHL_W  = 4;
	localparam int PROT_W = 8;
	localparam int IPA_W  = 32;

	// byte offsets inside the frame
	localparam logic [LEN_W-1:0] OFS_DMAC_LAST = LEN_W'(5);
	localparam logic [LEN_W-1:0] OFS_SMAC_LAST = LEN_W'(11);
	localparam logic [LEN_W-1:0] OFS_ETYP_LAST = LEN_W'(13);
	localparam logic [LEN_W-1:0] OFS_IHL       = LEN_W'(14);
	localparam logic [LEN_W-1:0] OFS_PROT      = LEN_W'(23);
	localparam logic [LEN_W-1:0] OFS_IPSRC_LO  = LEN_W'(26);
	localparam logic [LEN_W-1:0] OFS_IPSRC_HI  = LEN_W'(29);
	localparam logic [LEN_W-1:0] OFS_IPDST_LO  = LEN_W'(30);
	localparam logic [LEN_W-1:0] OFS_IPDST_HI  = LEN_W'(33);

	localparam logic [LEN_W-1:0] ETH_HDR_BYTES  = LEN_W'(14);
	localparam logic [LEN_W-1:0] IPV4_MIN_FRAME = LEN_W'(34);
	localparam logic [5:0]       IPV4_MIN_HLEN  = 6'd20;

	localparam logic [ETYP_W-1:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [ETYP_W-1:0] ETYPE_ARP  = 16'h0806;
	localparam logic [ETYP_W-1:0] ETYPE_IPV6 = 16'h86DD;

	localparam logic [PROT_W-1:0] PROT_ICMP = 8'd1;
	localparam logic [PROT_W-1:0] PROT_TCP  = 8'd6;
	localparam logic [PROT_W-1:0] PROT_UDP  = 8'd17;

	// frame queue between capture and classify
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_RUNT       = 3'd0,
		ST_NON_IPV4   = 3'd1,
		ST_IPV4_SHORT = 3'd2,
		ST_BAD_IHL    = 3'd3,
		ST_IPV4_OK    = 3'd4
	} frame_status_t;

	typedef enum logic [1:0] {
		EC_IPV4  = 2'd0,
		EC_ARP   = 2'd1,
		EC_IPV6  = 2'd2,
		EC_OTHER = 2'd3
	} ether_class_t;

	typedef enum logic [1:0] {
		PC_ICMP  = 2'd0,
		PC_TCP   = 2'd1,
		PC_UDP   = 2'd2,
		PC_OTHER = 2'd3
	} protocol_class_t;

	// raw fields of one frame as captured by the front end
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [MAC_W-1:0]  dmac;
		logic [MAC_W-1:0]  smac;
		logic [ETYP_W-1:0] etype;
		logic [IHL_W-1:0]  ihl;
		logic [PROT_W-1:0] prot;
		logic [IPA_W-1:0]  ipsrc;
		logic [IPA_W-1:0]  ipdst;
	} frame_rec_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} q_head_t;

	typedef struct packed {
		frame_status_t     status;
		ether_class_t      eclass;
		logic [ETYP_W-1:0] etype;
		logic [MAC_W-1:0]  dmac;
		logic [MAC_W-1:0]  smac;
		logic [IPA_W-1:0]  ipsrc;
		logic [IPA_W-1:0]  ipdst;
		logic [PROT_W-1:0] prot;
		protocol_class_t   pclass;
		logic [LEN_W-1:0]  len;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ehp_in_if.sv -----
// ----------------------------------------------------------------------------
// ehp_in_if
// Byte channel into the parser: one frame byte and its last-byte flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_frame;

	modport source (output valid, output data_byte, output end_of_frame, input ready);
	modport sink (input valid, input data_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ehp_out_if.sv -----
// ----------------------------------------------------------------------------
// ehp_out_if
// Result channel of the parser: one parsed header summary per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehp_out_if;
	logic                            valid;
	logic                            ready;
	ehp_pkg::frame_status_t          frame_status;
	ehp_pkg::ether_class_t           ether_class;
	logic [ehp_pkg::ETYP_W-1:0]      ether_type_value;
	logic [ehp_pkg::MAC_W-1:0]       dst_mac;
	logic [ehp_pkg::MAC_W-1:0]       source_mac;
	logic [ehp_pkg::IPA_W-1:0]       ip_source;
	logic [ehp_pkg::IPA_W-1:0]       ip_dest;
	logic [ehp_pkg::PROT_W-1:0]      ip_protocol;
	ehp_pkg::protocol_class_t        protocol_class;
	logic [ehp_pkg::LEN_W-1:0]       frame_length;

	modport source (
		output valid, output frame_status, output ether_class, output ether_type_value,
		output dst_mac, output source_mac, output ip_source, output ip_dest,
		output ip_protocol, output protocol_class, output frame_length, input ready
	);
	modport sink (
		input valid, input frame_status, input ether_class, input ether_type_value,
		input dst_mac, input source_mac, input ip_source, input ip_dest,
		input ip_protocol, input protocol_class, input frame_length, output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/ehp_front.sv -----
// ----------------------------------------------------------------------------
// ehp_front
// Byte capture: counts frame bytes and shifts header fields in at fixed offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_front #(
	parameter int MAX_FRAME_BYTES = 65536
) (
	input  wire                 clk,
	input  wire                 arst_n,
	ehp_in_if.sink              frame_in,
	input  wire                 q_full,
	output logic                q_push,
	output ehp_pkg::frame_rec_t q_data
);
	import ehp_pkg::*;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_BYTES);

	frame_rec_t cur_q;
	frame_rec_t nxt;
	logic       accept;

	assign frame_in.ready = !q_full;
	assign accept         = frame_in.valid && frame_in.ready;

	always_comb begin
		nxt = cur_q;
		if (cur_q.len < LEN_MAX) begin
			nxt.len = cur_q.len + LEN_W'(1);
			case (cur_q.len) inside
				[LEN_W'(0):OFS_DMAC_LAST]: begin
					nxt.dmac = {cur_q.dmac[MAC_W-9:0], frame_in.data_byte};
				end
				[OFS_DMAC_LAST+LEN_W'(1):OFS_SMAC_LAST]: begin
					nxt.smac = {cur_q.smac[MAC_W-9:0], frame_in.data_byte};
				end
				[OFS_SMAC_LAST+LEN_W'(1):OFS_ETYP_LAST]: begin
					nxt.etype = {cur_q.etype[ETYP_W-9:0], frame_in.data_byte};
				end
				OFS_IHL: begin
					nxt.ihl = frame_in.data_byte[IHL_W-1:0];
				end
				OFS_PROT: begin
					nxt.prot = frame_in.data_byte;
				end
				[OFS_IPSRC_LO:OFS_IPSRC_HI]: begin
					nxt.ipsrc = {cur_q.ipsrc[IPA_W-9:0], frame_in.data_byte};
				end
				[OFS_IPDST_LO:OFS_IPDST_HI]: begin
					nxt.ipdst = {cur_q.ipdst[IPA_W-9:0], frame_in.data_byte};
				end
				default: begin
				end
			endcase
		end
	end

	// the last beat hands the finished record to the queue and starts clean
	assign q_push = accept && frame_in.end_of_frame;
	assign q_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (accept) begin
			if (frame_in.end_of_frame) begin
				cur_q <= '0;
			end else begin
				cur_q <= nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ehp_queue.sv -----
// ----------------------------------------------------------------------------
// ehp_queue
// Short queue of captured frame records between the capture and classify sides.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  ehp_pkg::frame_rec_t push_data,
	output logic                full,
	input  wire                 pop,
	output ehp_pkg::q_head_t    head
);
	import ehp_pkg::*;

	frame_rec_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.rec   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ehp_back.sv -----
// ----------------------------------------------------------------------------
// ehp_back
// Classify: checks a captured record and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_back (
	input  wire              clk,
	input  wire              arst_n,
	input  ehp_pkg::q_head_t head,
	output logic             pop,
	ehp_out_if.source        hdr_out
);
	import ehp_pkg::*;

	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	frame_rec_t r;
	logic [5:0] hlen;
	logic       ok;

	assign r    = head.rec;
	assign hlen = {r.ihl, 2'b00};

	always_comb begin
		res       = '0;
		res.etype = r.etype;
		res.dmac  = r.dmac;
		res.smac  = r.smac;
		res.len   = r.len;

		case (r.etype)
			ETYPE_IPV4: res.eclass = EC_IPV4;
			ETYPE_ARP:  res.eclass = EC_ARP;
			ETYPE_IPV6: res.eclass = EC_IPV6;
			default:    res.eclass = EC_OTHER;
		endcase

		if (r.len < ETH_HDR_BYTES) begin
			res.status = ST_RUNT;
			res.eclass = EC_OTHER;
		end else if (r.etype != ETYPE_IPV4) begin
			res.status = ST_NON_IPV4;
		end else if (r.len < IPV4_MIN_FRAME) begin
			res.status = ST_IPV4_SHORT;
		end else if (hlen < IPV4_MIN_HLEN || r.len < ETH_HDR_BYTES + LEN_W'(hlen)) begin
			res.status = ST_BAD_IHL;
		end else begin
			res.status = ST_IPV4_OK;
		end

		ok = (res.status == ST_IPV4_OK);
		res.pclass = PC_OTHER;
		if (ok) begin
			res.ipsrc = r.ipsrc;
			res.ipdst = r.ipdst;
			res.prot  = r.prot;
			case (r.prot)
				PROT_ICMP: res.pclass = PC_ICMP;
				PROT_TCP:  res.pclass = PC_TCP;
				PROT_UDP:  res.pclass = PC_UDP;
				default:   res.pclass = PC_OTHER;
			endcase
		end
	end

	// output register refills whenever it is empty or being drained and the queue holds a record
	assign pop = head.valid && (!out_valid_q || hdr_out.ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (hdr_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign hdr_out.valid            = out_valid_q;
	assign hdr_out.frame_status     = res_q.status;
	assign hdr_out.ether_class      = res_q.eclass;
	assign hdr_out.ether_type_value = res_q.etype;
	assign hdr_out.dst_mac          = res_q.dmac;
	assign hdr_out.source_mac       = res_q.smac;
	assign hdr_out.ip_source        = res_q.ipsrc;
	assign hdr_out.ip_dest          = res_q.ipdst;
	assign hdr_out.ip_protocol      = res_q.prot;
	assign hdr_out.protocol_class   = res_q.pclass;
	assign hdr_out.frame_length     = res_q.len;

endmodule

`default_nettype wire

// ----- rtl/core/ethernet_ipv4_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser_core
// Ethernet / IPv4 header parser: one byte per beat in, one summary per frame out.
// ----------------------------------------------------------------------------
// frame_in carries one frame byte per beat with end_of_frame on its last byte.
// hdr_out carries one result per frame: MACs, EtherType and its class, the
// IPv4 protocol and addresses, frame length and a status code.
// Throughput: one byte per clock while the frame queue is not full; frames may
// follow each other with no gap. The edge that accepts the last beat writes
// the frame queue; the output register takes the result from the queue head
// when that register is empty or being drained.
// The capture side and the output register are parted by a two-entry frame
// queue. When hdr_out stalls, results wait in the output register and the
// queue; frame_in drops ready only while the queue is full, which takes at
// least three completed frames held back by the receiver (one in the output
// register, two in the queue).
// The byte counter stops at MAX_FRAME_BYTES; further bytes are taken and
// ignored and frame_length reports MAX_FRAME_BYTES.
// Reset clears the capture registers, the queue and the output valid; no
// clearing pass is needed, the first byte may arrive right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ipv4_header_parser_core #(
	parameter int MAX_FRAME_BYTES = 65536
) (
	input  wire       clk,
	input  wire       arst_n,
	ehp_in_if.sink    frame_in,
	ehp_out_if.source hdr_out
);
	import ehp_pkg::*;

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	frame_rec_t q_data;
	q_head_t    q_head;

	ehp_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame_in(frame_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	ehp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	ehp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.hdr_out(hdr_out)
	);

	// a finished frame must never arrive at a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame record pushed into full queue");

	a_ok_is_ipv4: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_out.valid && hdr_out.frame_status == ST_IPV4_OK) |->
		(hdr_out.ether_class == EC_IPV4 && hdr_out.frame_length >= IPV4_MIN_FRAME))
		else $error("ipv4 ok status without ipv4 ethertype or full header");

	a_not_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_out.valid && hdr_out.frame_status != ST_IPV4_OK) |->
		(hdr_out.protocol_class == PC_OTHER && hdr_out.ip_protocol == '0 &&
		 hdr_out.ip_source == '0 && hdr_out.ip_dest == '0))
		else $error("ip fields not cleared on non-ok frame");

	a_runt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_out.valid && hdr_out.frame_status == ST_RUNT) |->
		(hdr_out.frame_length < ETH_HDR_BYTES && hdr_out.ether_class == EC_OTHER))
		else $error("runt status on a frame of full ethernet header length");

endmodule

`default_nettype wire
